### design/mstl_pkg.sv
// Shared types and codes for the multi-slot tick timer list.
`timescale 1ns / 1ps
package mstl_pkg;

  typedef logic [1:0]  func_t;
  typedef logic [3:0]  slot_t;
  typedef logic [31:0] interval_t;

  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic  push;
    logic  flush;
    slot_t slot;
    logic  fin;
  } buf_ctl_t;

  typedef struct packed {
    logic pend_valid;
    logic can_push;
  } buf_stat_t;

endpackage

### design/mstl_if.sv
// Handshake channels for timer items and expiry results.
`timescale 1ns / 1ps
interface mstl_in_if;
  import mstl_pkg::*;
  logic      valid;
  logic      ready;
  func_t     func;
  slot_t     slot;
  interval_t interval;
  logic      one_shot;
  modport source (output valid, func, slot, interval, one_shot, input ready);
  modport sink   (input valid, func, slot, interval, one_shot, output ready);
endinterface

interface mstl_out_if;
  import mstl_pkg::*;
  logic  valid;
  logic  ready;
  slot_t expired_slot;
  logic  finished;
  logic  last;
  modport source (output valid, expired_slot, finished, last, input ready);
  modport sink   (input valid, expired_slot, finished, last, output ready);
endinterface

### design/mstl_result_buf.sv
// Pending expiry holder and output register that places the last mark.
`timescale 1ns / 1ps
module mstl_result_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  mstl_pkg::buf_ctl_t  ctl,
  output mstl_pkg::buf_stat_t stat,
  mstl_out_if.source          out_ch
);
  import mstl_pkg::*;

  logic  pend_valid_r;
  slot_t pend_slot_r;
  logic  pend_fin_r;
  logic  out_valid_r;
  slot_t out_slot_r;
  logic  out_fin_r;
  logic  out_last_r;
  logic  out_free;

  assign out_free        = !out_valid_r || out_ch.ready;
  assign stat.pend_valid = pend_valid_r;
  assign stat.can_push   = !pend_valid_r || out_free;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.expired_slot = out_slot_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.push && pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        out_slot_r   <= pend_slot_r;
        out_fin_r    <= pend_fin_r;
        out_last_r   <= 1'b0;
        pend_slot_r  <= ctl.slot;
        pend_fin_r   <= ctl.fin;
      end else if (ctl.push && !pend_valid_r) begin
        pend_valid_r <= 1'b1;
        pend_slot_r  <= ctl.slot;
        pend_fin_r   <= ctl.fin;
        if (out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
      end else if (ctl.flush && pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        out_slot_r   <= pend_slot_r;
        out_fin_r    <= pend_fin_r;
        out_last_r   <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_slot_r)
      && $stable(out_fin_r) && $stable(out_last_r))
    else $error("result changed while the receiver stalled");
  a_rise_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_valid_r))
    else $error("result appeared without a pending expiry");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !ctl.flush)
    else $error("push and flush in the same cycle");

endmodule

### design/multi_slot_tick_timer_list_top.sv
// Top level of the multi-slot tick timer list: slot memory and tick walker.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries items: func add arms a slot with interval and one_shot
//   (re-adding restarts it), func remove disarms a slot, func tick advances
//   every armed slot by one tick. Add, remove and unused codes produce
//   no result. A tick walks the slots one per cycle, unless an expiry
//   stalls it, through a slot memory with one read and one write port
//   (one read, one decrement and compare, one write-back per cycle).
//   During a tick in_ch.ready stays low until the walk over the first
//   min(NUM_SLOTS,16) slots ends and no expiry is left pending.
//   Each expiring slot yields one item on out_ch in ascending slot order;
//   the final one of a tick carries last. An expiry is held pending until
//   the next expiry is found, or until the walk ends for the final one,
//   and then moves to the output register.
//   When out_ch stalls, one expiry is held pending and one sits in the
//   output register; a further expiry freezes the walk until space frees.
//   The next item is accepted while the final result still waits.
//   Reset clears all armed bits at once; the slot memory needs no clearing
//   pass since an entry is always written in the cycle its slot is armed.
module multi_slot_tick_timer_list_top #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mstl_in_if.sink    in_ch,
  mstl_out_if.source out_ch
);
  import mstl_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W  = IDX_W + 1;
  localparam int WALK   = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int ENTRY_W = 2 * COUNT_WIDTH + 1;

  typedef enum logic {ST_IDLE, ST_WALK} state_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  state_t             state_r;
  logic [PTR_W-1:0]   rd_idx_r;
  logic [PTR_W-1:0]   proc_idx_r;
  logic               proc_valid_r;
  logic [NUM_SLOTS-1:0] armed_r;

  logic [ENTRY_W-1:0] mem [NUM_SLOTS];
  logic [ENTRY_W-1:0] rdata_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [IDX_W+3:0]        slot_wide;
  logic                    slot_ok;
  logic [IDX_W-1:0]        slot_addr;
  logic [COUNT_WIDTH+31:0] ival_wide;
  count_t                  ival;
  logic                    in_fire;

  logic [IDX_W-1:0] proc_addr;
  logic [IDX_W+3:0] proc_wide;
  logic             rd_fire;
  count_t           rd_rem;
  count_t           rd_reload;
  count_t           rem_dec;
  logic             proc_armed;
  logic             hit;
  logic             stall;
  logic             issue;
  logic             walk_end;

  buf_ctl_t  bctl;
  buf_stat_t bstat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign slot_wide = {{IDX_W{1'b0}}, in_ch.slot};
  assign slot_ok   = slot_wide < (IDX_W + 4)'(NUM_SLOTS);
  assign slot_addr = slot_wide[IDX_W-1:0];
  assign ival_wide = {{COUNT_WIDTH{1'b0}}, in_ch.interval};
  assign ival      = ival_wide[COUNT_WIDTH-1:0];

  assign proc_addr  = proc_idx_r[IDX_W-1:0];
  assign proc_wide  = {4'b0, proc_addr};
  assign rd_fire    = rdata_r[ENTRY_W-1];
  assign rd_reload  = rdata_r[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign rd_rem     = rdata_r[COUNT_WIDTH-1:0];
  assign rem_dec    = rd_rem - count_t'(1);
  assign proc_armed = proc_valid_r && armed_r[proc_addr];
  assign hit        = proc_armed && (rem_dec == '0);
  assign stall      = hit && !bstat.can_push;
  assign issue      = (state_r == ST_WALK) && !stall && (rd_idx_r < PTR_W'(WALK));
  assign walk_end   = (state_r == ST_WALK) && !proc_valid_r && !issue;
  assign rd_addr    = stall ? proc_addr : rd_idx_r[IDX_W-1:0];

  assign bctl.push  = hit && bstat.can_push;
  assign bctl.flush = walk_end;
  assign bctl.slot  = proc_wide[3:0];
  assign bctl.fin   = rd_fire;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_addr;
    mem_wdata = rdata_r;
    if (in_fire && in_ch.func == FUNC_ADD && slot_ok) begin
      mem_we    = 1'b1;
      mem_waddr = slot_addr;
      mem_wdata = {in_ch.one_shot, ival, ival};
    end else if (proc_armed && !stall) begin
      mem_we    = 1'b1;
      mem_waddr = proc_addr;
      mem_wdata = {rd_fire, rd_reload, hit ? rd_reload : rem_dec};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  mstl_result_buf u_result_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (bctl),
    .stat   (bstat),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      proc_idx_r   <= '0;
      proc_valid_r <= 1'b0;
      armed_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          proc_valid_r <= 1'b0;
          if (in_fire) begin
            case (in_ch.func)
              FUNC_ADD: begin
                if (slot_ok) begin
                  armed_r[slot_addr] <= 1'b1;
                end
              end
              FUNC_REMOVE: begin
                if (slot_ok) begin
                  armed_r[slot_addr] <= 1'b0;
                end
              end
              FUNC_TICK: begin
                rd_idx_r <= '0;
                state_r  <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (hit && !stall && rd_fire) begin
            armed_r[proc_addr] <= 1'b0;
          end
          if (issue) begin
            proc_valid_r <= 1'b1;
            proc_idx_r   <= rd_idx_r;
            rd_idx_r     <= rd_idx_r + PTR_W'(1);
          end else if (!stall) begin
            proc_valid_r <= 1'b0;
          end
          if (walk_end && !bstat.pend_valid) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_proc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    proc_valid_r |-> state_r == ST_WALK)
    else $error("slot processed outside a tick walk");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> proc_valid_r && $stable(proc_idx_r))
    else $error("walk advanced past a refused expiry");
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !bstat.pend_valid)
    else $error("idle with an expiry still pending");
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= PTR_W'(WALK))
    else $error("walk pointer beyond slot range");

endmodule
